// ===== hdl/npci_pkg.sv =====
// npci_pkg: types and constants shared by the nearest palette colour index core
// holds request/response payloads, chain item types and the operation codes
// no dependencies
`default_nettype none

package npci_pkg;

   // palette size and derived widths
   localparam int PALETTE_DEPTH = 256;
   localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CHAN_W        = 8;
   localparam int SLOT_W        = 8;
   localparam int COUNT_W       = 9;
   localparam int DIST_W        = 18;
   localparam int SQ_W          = 2 * CHAN_W;
   localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(3 * 255 * 255);

   // operation codes
   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } op_type;

   // request item
   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   entry_index;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
   } req_payload_type;

   // response item
   typedef struct packed {
      logic [SLOT_W-1:0]   nearest_index;
      logic                index_valid;
      logic [DIST_W-1:0]   best_distance_sq;
   } rsp_payload_type;

   // item handed from cell to cell
   typedef struct packed {
      logic                valid;
      req_payload_type     req;
      logic [SLOT_W-1:0]   best_index;
      logic                best_valid;
      logic [DIST_W-1:0]   best_dist;
   } chain_type;

   // inner stage of a cell: the item plus this cell's candidate distance
   typedef struct packed {
      chain_type           item;
      logic                take;
      logic [DIST_W-1:0]   cand_dist;
   } stage_type;

endpackage

`default_nettype wire

// ===== hdl/nearest_palette_color_index_core.sv =====
// nearest_palette_color_index_core: top level of the nearest palette colour search
// a chain of npci_cell instances, one per palette slot, plus the response register
// depends on npci_pkg and npci_cell
`default_nettype none

// The core takes one item per clock once the chain is flowing. Every item, pixel or
// palette load, walks through a chain of PALETTE_DEPTH cells, one cell per palette slot,
// each cell holding two registers (distance, then compare); the last cell feeds the
// response register that offers a pixel's response. Loads travel the same chain and
// update their slot as they pass, so a pixel always sees exactly the loads that were
// sent before it; loads give no response. The whole chain stalls while a response
// waits in the output register and rsp_ready is low. Entries beyond palette_count are
// skipped; an empty palette gives index_valid 0 with zero index and distance. Ties go
// to the lowest index. Write palette_count only while no item is in flight.
module nearest_palette_color_index_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire npci_pkg::req_payload_type     req_payload,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      npci_pkg::rsp_payload_type     rsp_payload,
   input  wire logic                          csr_write_en,
   input  wire logic [npci_pkg::COUNT_W-1:0]  csr_write_data
);
   import npci_pkg::*;

   logic [COUNT_W-1:0] palette_count_ff;
   logic               adv;
   chain_type          chain [PALETTE_DEPTH+1];
   chain_type          tail;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_payload_type    rsp_payload_ff;

   // palette count register
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_count_ff <= '0;
      end else if (csr_write_en) begin
         palette_count_ff <= csr_write_data;
      end
   end

   // chain moves whenever the response register can take what leaves it
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // head of the chain: new item with an empty best match
   always_comb begin
      chain[0].valid      = req_valid;
      chain[0].req        = req_payload;
      chain[0].best_index = '0;
      chain[0].best_valid = 1'b0;
      chain[0].best_dist  = '0;
   end

   // one cell per palette slot
   for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
      npci_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .adv           (adv),
         .cell_index    (IDX_W'(g)),
         .palette_count (palette_count_ff),
         .chain_i       (chain[g]),
         .chain_o       (chain[g+1])
      );
   end

   assign tail = chain[PALETTE_DEPTH];

   // response register, loads are dropped at the tail
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = tail.valid && tail.req.op == OP_PIXEL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && tail.valid && tail.req.op == OP_PIXEL) begin
         rsp_payload_ff.nearest_index    <= tail.best_index;
         rsp_payload_ff.index_valid      <= tail.best_valid;
         rsp_payload_ff.best_distance_sq <= tail.best_dist;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // nothing is offered in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid right after reset");

   // a no-match response carries zero index and distance
   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.index_valid
      |-> rsp_payload_ff.nearest_index == '0 && rsp_payload_ff.best_distance_sq == '0)
      else $error("no-match response with non-zero fields");

   // distance stays within three full-scale squared channels
   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_payload_ff.best_distance_sq <= MAX_DIST)
      else $error("distance out of range");

endmodule

`default_nettype wire

// ===== hdl/npci_cell.sv =====
// npci_cell: one slot of the palette chain, holds one colour entry
// computes the distance to its entry, then keeps the nearer of it and the best so far
// depends on npci_pkg
`default_nettype none

module npci_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic [npci_pkg::IDX_W-1:0]  cell_index,
   input  wire logic [npci_pkg::COUNT_W-1:0] palette_count,
   input  wire npci_pkg::chain_type         chain_i,
   output      npci_pkg::chain_type         chain_o
);
   import npci_pkg::*;

   logic [3*CHAN_W-1:0] entry_ff;
   stage_type           s1_ff;
   stage_type           s1_in;
   chain_type           out_ff;
   chain_type           out_in;

   logic [CHAN_W-1:0]   d_r;
   logic [CHAN_W-1:0]   d_g;
   logic [CHAN_W-1:0]   d_b;
   logic [SQ_W-1:0]     sq_r;
   logic [SQ_W-1:0]     sq_g;
   logic [SQ_W-1:0]     sq_b;
   logic                in_range;
   logic                is_mine;

   // slot match for loads, range check against the active count
   assign is_mine  = ({1'b0, chain_i.req.entry_index} == (SLOT_W + 1)'(cell_index));
   assign in_range = (COUNT_W'(cell_index) < palette_count);

   // entry store, written as a load item passes this cell
   always_ff @(posedge clock) begin
      if (adv && chain_i.valid && chain_i.req.op == OP_LOAD && is_mine) begin
         entry_ff <= {chain_i.req.red, chain_i.req.green, chain_i.req.blue};
      end
   end

   // absolute channel differences and their squares
   always_comb begin
      d_r = (entry_ff[23:16] > chain_i.req.red) ? entry_ff[23:16] - chain_i.req.red
                                                : chain_i.req.red - entry_ff[23:16];
      d_g = (entry_ff[15:8] > chain_i.req.green) ? entry_ff[15:8] - chain_i.req.green
                                                 : chain_i.req.green - entry_ff[15:8];
      d_b = (entry_ff[7:0] > chain_i.req.blue) ? entry_ff[7:0] - chain_i.req.blue
                                               : chain_i.req.blue - entry_ff[7:0];
      sq_r = SQ_W'(d_r) * SQ_W'(d_r);
      sq_g = SQ_W'(d_g) * SQ_W'(d_g);
      sq_b = SQ_W'(d_b) * SQ_W'(d_b);
      s1_in.item      = chain_i;
      s1_in.take      = chain_i.valid && chain_i.req.op == OP_PIXEL && in_range;
      s1_in.cand_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
   end

   // distance stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.item.valid <= 1'b0;
      end else if (adv) begin
         s1_ff <= s1_in;
      end
   end

   // strict compare keeps the lowest index on a tie
   always_comb begin
      out_in = s1_ff.item;
      if (s1_ff.take && (!s1_ff.item.best_valid || s1_ff.cand_dist < s1_ff.item.best_dist)) begin
         out_in.best_index = SLOT_W'(cell_index);
         out_in.best_valid = 1'b1;
         out_in.best_dist  = s1_ff.cand_dist;
      end
   end

   // compare stage register, handed on to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         out_ff <= out_in;
      end
   end

   assign chain_o = out_ff;

   // the best distance never grows as an item moves through a cell
   a_dist_monotone: assert property (@(posedge clock) disable iff (reset)
      adv && s1_ff.item.valid && s1_ff.item.best_valid
      |=> out_ff.best_valid && out_ff.best_dist <= $past(s1_ff.item.best_dist))
      else $error("best distance grew in a cell");

   // a load for this slot leaves its colour in the entry
   a_load_lands: assert property (@(posedge clock) disable iff (reset)
      adv && chain_i.valid && chain_i.req.op == OP_LOAD && is_mine
      |=> entry_ff == $past({chain_i.req.red, chain_i.req.green, chain_i.req.blue}))
      else $error("palette load did not reach its entry");

   // cells beyond the active count never claim the best
   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      adv && s1_ff.item.valid && !s1_ff.take
      |=> out_ff.best_index == $past(s1_ff.item.best_index)
          && out_ff.best_dist == $past(s1_ff.item.best_dist))
      else $error("inactive cell changed the best match");

endmodule

`default_nettype wire

// ===== dv/npci_match_checker.sv =====
// npci_match_checker: watches the request, response and register ports of the core
// keeps its own palette and count, works out the nearest colour for every pixel taken
// depends on npci_pkg
module npci_match_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire npci_pkg::req_payload_type     req_payload,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire npci_pkg::rsp_payload_type     rsp_payload,
   input  wire logic                          csr_write_en,
   input  wire logic [npci_pkg::COUNT_W-1:0]  csr_write_data,
   output int                                 mismatch_count,
   output int                                 matches_awaited
);
   timeunit 1ns;
   timeprecision 1ps;
   import npci_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } colour_type;

   colour_type         palette_colour [PALETTE_DEPTH];
   logic [COUNT_W-1:0] entries_in_use = '0;
   rsp_payload_type    expected_matches [$];
   int                 failed = 0;
   int                 awaited = 0;

   assign mismatch_count  = failed;
   assign matches_awaited = awaited;

   // squared difference of one channel
   function automatic int unsigned gap_sq(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
   endfunction

   // search the entries in use, keeping the first entry of the smallest distance
   function automatic rsp_payload_type nearest_colour(input req_payload_type px);
      rsp_payload_type best;
      int unsigned     span;
      int unsigned     gap_total;
      int unsigned     best_dist;
      int unsigned     i;
      best      = '0;
      best_dist = 0;
      span      = (entries_in_use > PALETTE_DEPTH) ? PALETTE_DEPTH : entries_in_use;
      for (i = 0; i < span; i++) begin
         gap_total = gap_sq(palette_colour[i].red, px.red)
                   + gap_sq(palette_colour[i].green, px.green)
                   + gap_sq(palette_colour[i].blue, px.blue);
         if (!best.index_valid || gap_total < best_dist) begin
            best_dist          = gap_total;
            best.nearest_index = SLOT_W'(i);
            best.index_valid   = 1'b1;
         end
      end
      best.best_distance_sq = DIST_W'(best_dist);
      return best;
   endfunction

   always @(posedge clock) begin : watch_channels
      rsp_payload_type want;
      if (reset) begin
         entries_in_use = '0;
         expected_matches.delete();
      end else begin
         // register write, only made while nothing is in flight
         if (csr_write_en) begin
            entries_in_use = csr_write_data;
         end
         // a result always belongs to an item taken earlier, so check it first
         if (rsp_valid && rsp_ready) begin
            if (expected_matches.size() == 0) begin
               failed++;
               $display("%0t: unexpected result, actual index %0d valid %0b distance %0d",
                        $time, rsp_payload.nearest_index, rsp_payload.index_valid,
                        rsp_payload.best_distance_sq);
            end else begin
               want = expected_matches.pop_front();
               if (rsp_payload.nearest_index !== want.nearest_index ||
                   rsp_payload.index_valid !== want.index_valid ||
                   rsp_payload.best_distance_sq !== want.best_distance_sq) begin
                  failed++;
                  $display("%0t: index/valid/distance expected %0d/%0b/%0d, actual %0d/%0b/%0d",
                           $time, want.nearest_index, want.index_valid,
                           want.best_distance_sq, rsp_payload.nearest_index,
                           rsp_payload.index_valid, rsp_payload.best_distance_sq);
               end
            end
         end
         // item taken: a load updates the palette, a pixel queues its answer
         if (req_valid && req_ready) begin
            if (req_payload.op == OP_LOAD) begin
               palette_colour[req_payload.entry_index] =
                  {req_payload.red, req_payload.green, req_payload.blue};
            end else begin
               expected_matches.push_back(nearest_colour(req_payload));
            end
         end
      end
      awaited = expected_matches.size();
   end

endmodule

// ===== dv/tb_nearest_palette_color_index_core.sv =====
// tb_nearest_palette_color_index_core: stimulus and verdict for the nearest palette colour core
// sends palette loads, pixels and palette_count writes; checking sits in npci_match_checker
// depends on npci_pkg, nearest_palette_color_index_core and npci_match_checker
module tb_nearest_palette_color_index_core;
   timeunit 1ns;
   timeprecision 1ps;
   import npci_pkg::*;

   // chain latency plus margin, so loads still walking the chain have landed
   localparam int SETTLE_CYCLES = 2 * PALETTE_DEPTH + 32;
   localparam int IDLE_PERCENT  = 7;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } colour_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_payload_type    req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_payload_type    rsp_payload;
   logic               csr_write_en = 1'b0;
   logic [COUNT_W-1:0] csr_write_data = '0;
   bit                 idling = 1'b1;
   int                 mismatch_count;
   int                 matches_awaited;

   // palette as loaded so far, used to aim pixels close to existing colours
   colour_type         shadow_colour [PALETTE_DEPTH];
   bit                 slot_loaded [PALETTE_DEPTH];

   nearest_palette_color_index_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   npci_match_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .mismatch_count  (mismatch_count),
      .matches_awaited (matches_awaited)
   );

   always #5 clock = ~clock;

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= !(idling && $urandom_range(99) < IDLE_PERCENT);
   end

   // channel value: coarse levels give ties, extremes give the distance limits
   function automatic logic [CHAN_W-1:0] pick_channel();
      int unsigned v;
      case ($urandom_range(3))
         0: begin
            v = $urandom_range(4) * 64;
            return (v > 255) ? CHAN_W'(255) : CHAN_W'(v);
         end
         1: return $urandom_range(1) ? CHAN_W'(255) : CHAN_W'(0);
         default: return CHAN_W'($urandom_range(255));
      endcase
   endfunction

   // small random offset, clamped to the channel range
   function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(8)) - 4;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return CHAN_W'(v);
   endfunction

   // one item, entered and left at a falling edge
   task automatic send_item(input req_payload_type item);
      while (idling && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic load_slot(input int unsigned slot, input logic [CHAN_W-1:0] r,
                            input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
      req_payload_type item;
      item.op          = OP_LOAD;
      item.entry_index = SLOT_W'(slot);
      item.red         = r;
      item.green       = g;
      item.blue        = b;
      shadow_colour[slot] = {r, g, b};
      slot_loaded[slot]   = 1'b1;
      send_item(item);
   endtask

   task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
      req_payload_type item;
      item.op          = OP_PIXEL;
      item.entry_index = SLOT_W'($urandom_range(255));
      item.red         = r;
      item.green       = g;
      item.blue        = b;
      send_item(item);
   endtask

   // drain all results, then let trailing loads clear the chain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (matches_awaited != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(input int unsigned count);
      csr_write_en   <= 1'b1;
      csr_write_data <= COUNT_W'(count);
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // one palette_count setting: fill the searched slots, then mixed loads and pixels
   task automatic run_phase(input int unsigned count, input int unsigned n_items);
      int unsigned span;
      int unsigned slot;
      int unsigned i;
      colour_type  near;
      span = (count > PALETTE_DEPTH) ? PALETTE_DEPTH : count;
      wait_idle();
      write_count(count);
      for (slot = 0; slot < span; slot++) begin
         if (!slot_loaded[slot]) begin
            load_slot(slot, pick_channel(), pick_channel(), pick_channel());
         end
      end
      for (i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 25) begin
            if (span != 0 && $urandom_range(99) < 70) begin
               slot = $urandom_range(span - 1);
            end else begin
               slot = $urandom_range(PALETTE_DEPTH - 1);
            end
            load_slot(slot, pick_channel(), pick_channel(), pick_channel());
         end else if (span != 0 && $urandom_range(99) < 40) begin
            near = shadow_colour[$urandom_range(span - 1)];
            send_pixel(nudge(near.red), nudge(near.green), nudge(near.blue));
         end else begin
            send_pixel(pick_channel(), pick_channel(), pick_channel());
         end
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // empty palette straight out of reset
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      // duplicate colours and an equidistant pair for the lowest index rule
      load_slot(0, 8'd0, 8'd0, 8'd0);
      load_slot(1, 8'd255, 8'd255, 8'd255);
      load_slot(2, 8'd255, 8'd0, 8'd0);
      load_slot(3, 8'd0, 8'd0, 8'd0);
      load_slot(4, 8'd20, 8'd0, 8'd0);
      load_slot(5, 8'd10, 8'd0, 8'd0);
      load_slot(255, 8'd0, 8'd255, 8'd0);
      // single entry: largest possible distance
      wait_idle();
      write_count(1);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
      // six entries: exact duplicate, tie between slots 4 and 5, clear winners
      wait_idle();
      write_count(6);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd15, 8'd0, 8'd0);
      send_pixel(8'd128, 8'd0, 8'd0);
      send_pixel(8'd200, 8'd200, 8'd200);
      send_pixel(8'd0, 8'd255, 8'd255);
      // count written back to zero
      wait_idle();
      write_count(0);
      send_pixel(8'd90, 8'd91, 8'd92);

      // random part over several counts, beyond-depth ones included
      run_phase(3, 110);
      run_phase(PALETTE_DEPTH, 140);
      run_phase(511, 110);
      run_phase(2, 90);
      idling <= 1'b0;
      run_phase(16, 150);
      idling <= 1'b1;
      run_phase(257, 90);
      run_phase(1, 70);
      run_phase(0, 40);
      run_phase(300, 90);
      run_phase($urandom_range(3, 255), 140);
      run_phase($urandom_range(1, 256), 140);
      run_phase(255, 90);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/npci_pkg.sv
hdl/npci_cell.sv
hdl/nearest_palette_color_index_core.sv
dv/npci_match_checker.sv
dv/tb_nearest_palette_color_index_core.sv
